// ===== rtl/core/protobuf_scalar_encoder_defines.svh =====
// Assertion macros shared by the encoder modules.
`ifndef PROTOBUF_SCALAR_ENCODER_DEFINES_SVH
`define PROTOBUF_SCALAR_ENCODER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define PSE_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define PSE_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/pse_pkg.sv =====
// Types and constants shared by the scalar encoder modules.
`default_nettype none
package pse_pkg;

    typedef enum logic [3:0] {
        KIND_INT32    = 4'd0,
        KIND_INT64    = 4'd1,
        KIND_UINT32   = 4'd2,
        KIND_UINT64   = 4'd3,
        KIND_SINT32   = 4'd4,
        KIND_SINT64   = 4'd5,
        KIND_BOOL     = 4'd6,
        KIND_FIXED32  = 4'd7,
        KIND_SFIXED32 = 4'd8,
        KIND_FLOAT    = 4'd9,
        KIND_FIXED64  = 4'd10,
        KIND_SFIXED64 = 4'd11,
        KIND_DOUBLE   = 4'd12
    } t_kind;

    localparam logic [7:0] CONT_BIT   = 8'h80;
    localparam int         FIFO_DEPTH = 4;
    localparam int         FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int         FIFO_CW    = $clog2(FIFO_DEPTH + 1);

    // One classified value waiting for the byte emitter.
    typedef struct packed {
        logic [63:0] word;
        logic        varint;
        logic [3:0]  count;
    } t_pse_item;

endpackage
`default_nettype wire

// ===== rtl/core/protobuf_scalar_encoder.sv =====
// Top level of the Protocol Buffers scalar encoder.
//
//  Channel   Direction  Payload
//  s (in)    input      tdata = value[63:0], tuser = kind[3:0]
//  m (out)   output     tdata = out_byte[7:0], tlast = last_byte
//
// The output carries one byte a cycle while the sink is ready; a value has 1 to 10
// wire bytes, all sent by the single byte emitter in the back end.
// The front end classifies a word in the cycle it is taken and queues it
// (four entries), so input and output stall independently of each other.
// Words with an unused kind code are taken and produce no bytes.
// Reset is synchronous and active low; it empties the queue and the emitter.
`default_nettype none
module protobuf_scalar_encoder
    import pse_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [63:0] i_s_tdata,   // value[63:0]
    input  wire logic [3:0]  i_s_tuser,   // kind[3:0]
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic [7:0]       o_m_tdata,   // out_byte[7:0]
    output logic             o_m_tlast    // last_byte
);

    logic      w_push;
    t_pse_item w_in_item;
    logic      w_full;
    logic      w_pop;
    logic      w_q_valid;
    t_pse_item w_q_item;

    pse_front u_front (
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .i_full     (w_full),
        .o_push     (w_push),
        .o_item     (w_in_item)
    );

    pse_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_in_item),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_valid (w_q_valid),
        .o_item  (w_q_item)
    );

    pse_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (w_q_valid),
        .i_item     (w_q_item),
        .o_pop      (w_pop),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast)
    );

endmodule
`default_nettype wire

// ===== rtl/core/pse_front.sv =====
// Front end: accepts input words, maps them to a code word and byte count.
`default_nettype none
module pse_front
    import pse_pkg::*;
(
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [63:0] i_s_tdata,   // value[63:0]
    input  wire logic [3:0]  i_s_tuser,   // kind[3:0]
    input  wire logic        i_full,
    output logic             o_push,
    output t_pse_item        o_item
);

    logic [63:0] w_vi;
    logic        w_known;
    logic [3:0]  w_vcnt;

    always_comb begin
        w_vi    = i_s_tdata;
        w_known = 1'b1;
        o_item  = '0;
        unique case (i_s_tuser)
            KIND_INT32: begin
                w_vi = {{32{i_s_tdata[31]}}, i_s_tdata[31:0]};
            end
            KIND_INT64, KIND_UINT64: begin
                w_vi = i_s_tdata;
            end
            KIND_UINT32: begin
                w_vi = {32'd0, i_s_tdata[31:0]};
            end
            KIND_SINT32: begin
                w_vi = {32'd0, {i_s_tdata[30:0], 1'b0} ^ {32{i_s_tdata[31]}}};
            end
            KIND_SINT64: begin
                w_vi = {i_s_tdata[62:0], 1'b0} ^ {64{i_s_tdata[63]}};
            end
            default: begin
                w_vi = i_s_tdata;
            end
        endcase

        // Varint length: one byte per 7-bit group up to the highest non-zero group, at least one.
        w_vcnt = 4'd1;
        for (int k = 1; k < 10; k++) begin
            if ((w_vi >> (7 * k)) != 64'd0) begin
                w_vcnt = 4'(k + 1);
            end
        end

        unique case (i_s_tuser)
            KIND_INT32, KIND_INT64, KIND_UINT32, KIND_UINT64, KIND_SINT32, KIND_SINT64: begin
                o_item.word   = w_vi;
                o_item.varint = 1'b1;
                o_item.count  = w_vcnt;
            end
            KIND_BOOL: begin
                o_item.word   = {63'd0, |i_s_tdata};
                o_item.varint = 1'b0;
                o_item.count  = 4'd1;
            end
            KIND_FIXED32, KIND_SFIXED32, KIND_FLOAT: begin
                o_item.word   = i_s_tdata;
                o_item.varint = 1'b0;
                o_item.count  = 4'd4;
            end
            KIND_FIXED64, KIND_SFIXED64, KIND_DOUBLE: begin
                o_item.word   = i_s_tdata;
                o_item.varint = 1'b0;
                o_item.count  = 4'd8;
            end
            default: begin
                w_known = 1'b0;
            end
        endcase
    end

    // Words with an unused kind are taken and dropped.
    assign o_s_tready = !i_full;
    assign o_push     = i_s_tvalid && !i_full && w_known;

endmodule
`default_nettype wire

// ===== rtl/core/pse_fifo.sv =====
// Short queue of classified items between the front end and the emitter.
`default_nettype none
`include "protobuf_scalar_encoder_defines.svh"
module pse_fifo
    import pse_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_push,
    input  wire t_pse_item i_item,
    output logic           o_full,
    input  wire logic      i_pop,
    output logic           o_valid,
    output t_pse_item      o_item
);

    t_pse_item            r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0]   r_wr, n_wr;
    logic [FIFO_AW-1:0]   r_rd, n_rd;
    logic [FIFO_CW-1:0]   r_count, n_count;

    always_comb begin
        n_wr    = i_push ? FIFO_AW'(r_wr + 1'b1) : r_wr;
        n_rd    = i_pop  ? FIFO_AW'(r_rd + 1'b1) : r_rd;
        n_count = FIFO_CW'(r_count + FIFO_CW'(i_push) - FIFO_CW'(i_pop));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

    assign o_full  = (r_count == FIFO_CW'(FIFO_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rd];

    `PSE_ASSERT_NOW(a_no_overflow, i_clk, i_rst_n, i_push, !o_full || i_pop, "push into a full queue")
    `PSE_ASSERT_NOW(a_no_underflow, i_clk, i_rst_n, i_pop, o_valid, "pop from an empty queue")
    `PSE_ASSERT_NOW(a_count_range, i_clk, i_rst_n, 1'b1, r_count <= FIFO_CW'(FIFO_DEPTH), "queue count out of range")

endmodule
`default_nettype wire

// ===== rtl/core/pse_back.sv =====
// Back end: emits the bytes of one queued item at a time into the output register.
`default_nettype none
`include "protobuf_scalar_encoder_defines.svh"
module pse_back
    import pse_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_valid,
    input  wire t_pse_item i_item,
    output logic           o_pop,
    output logic           o_m_tvalid,
    input  wire logic      i_m_tready,
    output logic [7:0]     o_m_tdata,   // out_byte[7:0]
    output logic           o_m_tlast    // last_byte
);

    logic        r_busy, n_busy;
    logic [63:0] r_word, n_word;
    logic        r_varint, n_varint;
    logic [3:0]  r_left, n_left;
    logic        r_out_valid, n_out_valid;
    logic [7:0]  r_out_byte, n_out_byte;
    logic        r_out_last, n_out_last;

    logic       w_last;
    logic [7:0] w_byte;
    logic       w_adv;
    logic       w_load;

    always_comb begin
        w_last = (r_left == 4'd1);
        // Every varint byte but the last carries the continuation flag.
        w_byte = (r_varint && !w_last) ? (CONT_BIT | {1'b0, r_word[6:0]}) : r_word[7:0];
        w_adv  = r_busy && (!r_out_valid || i_m_tready);
        w_load = i_valid && (!r_busy || (w_adv && w_last));

        n_busy      = r_busy;
        n_word      = r_word;
        n_varint    = r_varint;
        n_left      = r_left;
        n_out_valid = r_out_valid;
        n_out_byte  = r_out_byte;
        n_out_last  = r_out_last;

        if (w_adv) begin
            n_out_valid = 1'b1;
            n_out_byte  = w_byte;
            n_out_last  = w_last;
            n_word      = r_varint ? (r_word >> 7) : (r_word >> 8);
            n_left      = r_left - 4'd1;
            if (w_last) begin
                n_busy = 1'b0;
            end
        end else if (i_m_tready) begin
            n_out_valid = 1'b0;
        end

        if (w_load) begin
            n_busy   = 1'b1;
            n_word   = i_item.word;
            n_varint = i_item.varint;
            n_left   = i_item.count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_busy      <= n_busy;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_word     <= n_word;
        r_varint   <= n_varint;
        r_left     <= n_left;
        r_out_byte <= n_out_byte;
        r_out_last <= n_out_last;
    end

    assign o_pop      = w_load;
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_byte;
    assign o_m_tlast  = r_out_last;

    `PSE_ASSERT_NOW(a_left_range, i_clk, i_rst_n, r_busy, (r_left != 4'd0) && (r_left <= 4'd10), "bytes left out of range while busy")
    `PSE_ASSERT_NEXT(a_cont_flag, i_clk, i_rst_n, w_adv && r_varint && !w_last, o_m_tdata[7] && !o_m_tlast, "varint byte lost its continuation flag")
    `PSE_ASSERT_NOW(a_load_when_free, i_clk, i_rst_n, w_load && r_busy, w_adv && w_last, "new item loaded over an unfinished one")

endmodule
`default_nettype wire
